// ===== src/ppsu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsu_pkg: shared types and constants for the palette pixel serializer
// Mode codes, config register indexes, work descriptor and palette lookup.
// ----------------------------------------------------------------------------
package ppsu_pkg;

  // display modes held in the mode register; codes above MODE_HITEXT are unknown
  typedef enum logic [3:0] {
    MODE_OFF    = 4'd0,
    MODE_HI2    = 4'd1,
    MODE_HI4    = 4'd2,
    MODE_HI16   = 4'd3,
    MODE_LO2    = 4'd4,
    MODE_LO4    = 4'd5,
    MODE_LO16   = 4'd6,
    MODE_LO256  = 4'd7,
    MODE_LOTEXT = 4'd8,
    MODE_HITEXT = 4'd9
  } mode_t;

  // config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_HIGH = 2'd2;

  localparam logic [63:0] PAL_LOW_RESET  = 64'h2010_0804_0201_FF00;
  localparam logic [63:0] PAL_HIGH_RESET = 64'h0604_0302_01C0_8040;

  localparam int unsigned SOLID_PIXELS  = 32;
  localparam int unsigned MAX_PIXELS    = 64;
  localparam int unsigned CNT_W         = $clog2(MAX_PIXELS);
  localparam logic [7:0]  MAGENTA_COLOR = 8'hC7;

  localparam int unsigned Q_DEPTH = 2;

  // how the back end walks a word
  typedef enum logic [2:0] {
    KIND_SOLID,   // raw color in word_a[7:0], repeated
    KIND_IDX1,    // 1-bit palette indexes
    KIND_IDX2,    // 2-bit palette indexes
    KIND_IDX4,    // 4-bit palette indexes
    KIND_HI16,    // nibbles alternating word_a / word_b
    KIND_LO256,   // raw bytes alternating word_a / word_b
    KIND_TEXT     // font row bits select fg / bg
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             dbl;       // each pixel emitted twice
    logic [CNT_W-1:0] last_idx;  // pixel count minus one
    logic [31:0]      word_a;
    logic [31:0]      word_b;
    logic [7:0]       font_row;
  } desc_t;

  function automatic logic [7:0] pal_lookup(input logic [127:0] pal,
                                            input logic [3:0] idx);
    pal_lookup = pal[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== src/ppsu_front.sv =====
// ----------------------------------------------------------------------------
// ppsu_front: input classifier
// Turns the mode and one input word set into a work descriptor.
// ----------------------------------------------------------------------------
module ppsu_front import ppsu_pkg::*; (
  input  mode_t       mode,
  input  logic [7:0]  pal_entry0,
  input  logic [31:0] in_word_a,
  input  logic [31:0] in_word_b,
  input  logic [7:0]  in_font_row,
  output desc_t       desc
);

  always_comb begin
    desc          = '0;
    desc.word_a   = in_word_a;
    desc.word_b   = in_word_b;
    desc.font_row = in_font_row;
    unique case (mode)
      MODE_OFF: begin
        desc.kind     = KIND_SOLID;
        desc.word_a   = {24'd0, pal_entry0};
        desc.last_idx = CNT_W'(SOLID_PIXELS - 1);
      end
      MODE_HI2: begin
        desc.kind     = KIND_IDX1;
        desc.last_idx = CNT_W'(31);
      end
      MODE_HI4: begin
        desc.kind     = KIND_IDX2;
        desc.last_idx = CNT_W'(15);
      end
      MODE_HI16: begin
        desc.kind     = KIND_HI16;
        desc.last_idx = CNT_W'(15);
      end
      MODE_LO2: begin
        desc.kind     = KIND_IDX1;
        desc.dbl      = 1'b1;
        desc.last_idx = CNT_W'(63);
      end
      MODE_LO4: begin
        desc.kind     = KIND_IDX2;
        desc.dbl      = 1'b1;
        desc.last_idx = CNT_W'(31);
      end
      MODE_LO16: begin
        desc.kind     = KIND_IDX4;
        desc.dbl      = 1'b1;
        desc.last_idx = CNT_W'(15);
      end
      MODE_LO256: begin
        desc.kind     = KIND_LO256;
        desc.last_idx = CNT_W'(7);
      end
      MODE_LOTEXT: begin
        desc.kind     = KIND_TEXT;
        desc.dbl      = 1'b1;
        desc.last_idx = CNT_W'(15);
      end
      MODE_HITEXT: begin
        desc.kind     = KIND_TEXT;
        desc.last_idx = CNT_W'(7);
      end
      default: begin
        desc.kind     = KIND_SOLID;
        desc.word_a   = {24'd0, MAGENTA_COLOR};
        desc.last_idx = CNT_W'(SOLID_PIXELS - 1);
      end
    endcase
  end

endmodule

// ===== src/ppsu_queue.sv =====
// ----------------------------------------------------------------------------
// ppsu_queue: descriptor queue
// Small FIFO between the classifier and the pixel generator.
// ----------------------------------------------------------------------------
module ppsu_queue import ppsu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  output logic  valid,
  output desc_t head,
  input  logic  pop
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(Q_DEPTH + 1);

  desc_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_QW'(Q_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_QW'(Q_DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_QW'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push without pop did not grow the queue");

endmodule

// ===== src/ppsu_back.sv =====
// ----------------------------------------------------------------------------
// ppsu_back: pixel generator
// Walks the head descriptor into the output register, one pixel per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ppsu_back import ppsu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  desc_t        q_head,
  output logic         q_pop,
  input  logic [127:0] palette,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [7:0]   out_color,
  output logic         out_last
);

  logic [CNT_W-1:0] pix_r, pix_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       color_r;
  logic             last_r;
  logic             load;
  logic             at_last;
  logic [4:0]       step;
  logic [31:0]      pair_word;
  logic [3:0]       idx;
  logic             use_raw;
  logic [7:0]       raw;
  logic [7:0]       pix_color;

  assign load    = q_valid && (!out_valid_r || out_pop);
  assign at_last = (pix_r == q_head.last_idx);
  assign q_pop   = load && at_last;

  // doubled modes hold each field for two pixels
  assign step      = q_head.dbl ? pix_r[5:1] : pix_r[4:0];
  assign pair_word = pix_r[0] ? q_head.word_b : q_head.word_a;

  always_comb begin
    idx     = '0;
    use_raw = 1'b0;
    raw     = q_head.word_a[7:0];
    unique case (q_head.kind)
      KIND_SOLID: use_raw = 1'b1;
      KIND_IDX1:  idx = {3'd0, q_head.word_a[step]};
      KIND_IDX2:  idx = {2'd0, q_head.word_a[{step[3:0], 1'b0} +: 2]};
      KIND_IDX4:  idx = q_head.word_a[{step[2:0], 2'b00} +: 4];
      KIND_HI16:  idx = pair_word[{pix_r[3:1], 2'b00} +: 4];
      KIND_LO256: begin
        use_raw = 1'b1;
        raw     = pair_word[{pix_r[2:1], 3'b000} +: 8];
      end
      KIND_TEXT:  idx = q_head.font_row[step[2:0]] ? q_head.word_a[11:8]
                                                   : q_head.word_a[15:12];
      default:    use_raw = 1'b1;
    endcase
  end

  assign pix_color = use_raw ? raw : pal_lookup(palette, idx);

  always_comb begin
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      pix_nxt       = at_last ? '0 : pix_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pix_r       <= pix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      color_r <= pix_color;
      last_r  <= at_last;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_color = color_r;
  assign out_last  = last_r;

  a_pix_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (pix_r <= q_head.last_idx))
    else $error("pixel counter past end of word");

  a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (pix_r == '0))
    else $error("pixel counter not cleared between words");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> (out_valid_r && $stable(color_r) && $stable(last_r)))
    else $error("output pixel lost while stalled");

endmodule

// ===== src/palette_pixel_serializer_unit.sv =====
// ----------------------------------------------------------------------------
// palette_pixel_serializer_unit: display word to pixel color serializer
// Expands each fetched word into a run of palette or raw 8-bit colors.
// ----------------------------------------------------------------------------
// Usage notes:
//   Input channel is a queue push side: a word set (in_word_a, in_word_b,
//   in_font_row) transfers on a clock edge with in_push high, in_full low.
//   Output channel is a queue pop side: while out_empty is low, out_color
//   and out_last show the oldest pixel; it transfers when out_pop is high.
//   out_last marks the final pixel of each input word.
//   Config: cfg_valid/cfg_ready write channel, cfg_ready is always high.
//   Index 0 pixel mode, 1 palette entries 0..7, 2 palette entries 8..15;
//   index 3 is ignored. Write only while no pixels are pending.
// Flow:
//   A word first lands in the queue; when the back end is free, its first
//   pixel is then loaded into the output register, ready to pop. Pixels
//   leave at one per clock while out_pop stays high; a word yields
//   8 to 64 pixels (hitext/lo256 8, hi16/hi4/lo16/lotext 16, hi2/lo4 32,
//   lo2 64, off/unknown 32).
//   The two-entry queue holds the word in progress and one more behind it,
//   so a new word is taken while the output stalls; in_full rises when the
//   queue fills.
// Reset: synchronous, clears mode to off, loads the default palette and
//   empties the queue and output register.
// ----------------------------------------------------------------------------
module palette_pixel_serializer_unit import ppsu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input word channel
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [31:0]          in_word_a,
  input  logic [31:0]          in_word_b,
  input  logic [7:0]           in_font_row,
  // pixel channel
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_color,
  output logic                 out_last,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  mode_t        mode_r;
  logic [63:0]  pal_low_r;
  logic [63:0]  pal_high_r;
  logic [127:0] palette;
  logic         cfg_we;

  desc_t        front_desc;
  desc_t        q_head;
  logic         q_valid;
  logic         q_pop;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign palette   = {pal_high_r, pal_low_r};

  // config registers; mode keeps only its low nibble
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_OFF;
      pal_low_r  <= PAL_LOW_RESET;
      pal_high_r <= PAL_HIGH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PIXEL_MODE) begin
        mode_r <= mode_t'(cfg_data[3:0]);
      end
      if (cfg_index == CFG_PALETTE_LOW) begin
        pal_low_r <= cfg_data;
      end
      if (cfg_index == CFG_PALETTE_HIGH) begin
        pal_high_r <= cfg_data;
      end
    end
  end

  // front end: classify the word under the current mode
  ppsu_front u_front (
    .mode        (mode_r),
    .pal_entry0  (pal_low_r[7:0]),
    .in_word_a   (in_word_a),
    .in_word_b   (in_word_b),
    .in_font_row (in_font_row),
    .desc        (front_desc)
  );

  // decoupling queue; its full flag is the input backpressure
  ppsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_desc),
    .full      (in_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  // back end: one pixel per cycle into the output register unless the output stalls
  ppsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .palette   (palette),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_color (out_color),
    .out_last  (out_last)
  );

endmodule

// ===== sim/palette_pixel_serializer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_pixel_serializer_unit_tb: self-checking bench for the pixel serializer
// Pushes display words under a range of modes and palettes and predicts every
// pixel color and end-of-word flag. Popped pixels are compared in order against
// that prediction, under random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module palette_pixel_serializer_unit_tb;
  import ppsu_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 6;    // extra wait at the end of each drain
  localparam int HOLD_CYCLES   = 300;  // long output stall for the pressure phase
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_WORDS   = 19;
  localparam int PRESS_WORDS   = 8;

  // index 3 has no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // mode codes above the defined set all mean "unknown"
  localparam logic [3:0] MODE_FIRST_UNKNOWN = 4'd10;
  localparam logic [3:0] MODE_LAST_UNKNOWN  = 4'd15;

  typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idling_t;

  typedef struct {
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [7:0]  font_row;
  } word_set_t;

  typedef struct {
    logic [7:0] color;
    logic       last;
  } pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [31:0]          in_word_a;
  logic [31:0]          in_word_b;
  logic [7:0]           in_font_row;
  logic                 out_empty;
  logic                 out_pop;
  logic [7:0]           out_color;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  // shadow copy of the register file, updated on each config transfer
  logic [3:0]  mode_reg;
  logic [63:0] pal_lo;
  logic [63:0] pal_hi;

  word_set_t words_to_send[$];
  pixel_t    pixels_due[$];

  int send_idle_pct;
  int recv_stall_pct;
  int err_cnt;
  int words_sent;
  int pixels_checked;
  int full_stalls;
  int cfg_writes;
  int cycle_cnt;

  logic hold_arm;
  int   hold_left;

  palette_pixel_serializer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_word_a   (in_word_a),
    .in_word_b   (in_word_b),
    .in_font_row (in_font_row),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_color   (out_color),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pixel prediction
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pal_color(input logic [3:0] idx);
    return idx[3] ? pal_hi[8*idx[2:0] +: 8] : pal_lo[8*idx[2:0] +: 8];
  endfunction

  // Expands one accepted word set into its pixel run under the current mode and
  // palette, and queues the run with the end flag on its final pixel.
  function automatic void predict_pixels(input logic [31:0] wa, input logic [31:0] wb,
                                         input logic [7:0] row);
    logic [7:0] run[$];
    logic [7:0] fg;
    logic [7:0] bg;
    logic [7:0] c;
    pixel_t     px;
    int         bits;
    int         reps;
    bits = 0;
    reps = 1;
    case (mode_reg)
      MODE_OFF:   repeat (SOLID_PIXELS) run.push_back(pal_color(4'd0));
      MODE_HI2:   bits = 1;
      MODE_HI4:   bits = 2;
      MODE_LO2:   begin bits = 1; reps = 2; end
      MODE_LO4:   begin bits = 2; reps = 2; end
      MODE_LO16:  begin bits = 4; reps = 2; end
      MODE_HI16: begin
        // nibbles alternate between the two banks, both through the palette
        for (int i = 0; i < 8; i++) begin
          run.push_back(pal_color(wa[4*i +: 4]));
          run.push_back(pal_color(wb[4*i +: 4]));
        end
      end
      MODE_LO256: begin
        // raw color bytes, no palette
        for (int i = 0; i < 4; i++) begin
          run.push_back(wa[8*i +: 8]);
          run.push_back(wb[8*i +: 8]);
        end
      end
      MODE_LOTEXT, MODE_HITEXT: begin
        fg = pal_color(wa[11:8]);
        bg = pal_color(wa[15:12]);
        if (mode_reg == MODE_LOTEXT) reps = 2;
        for (int j = 0; j < 8; j++) repeat (reps) run.push_back(row[j] ? fg : bg);
      end
      default: repeat (SOLID_PIXELS) run.push_back(MAGENTA_COLOR);
    endcase
    if (bits != 0) begin
      for (int i = 0; i < 32 / bits; i++) begin
        c = pal_color(4'((wa >> (bits * i)) & ((32'd1 << bits) - 32'd1)));
        repeat (reps) run.push_back(c);
      end
    end
    foreach (run[k]) begin
      px.color = run[k];
      px.last  = (k == run.size() - 1);
      pixels_due.push_back(px);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers the next pending word set, with random gaps.
  // A transfer is seen at the edge where push is high and full is low; the
  // prediction is taken from the values that were on the ports at that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    bit go;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_pixels(in_word_a, in_word_b, in_font_row);
        void'(words_to_send.pop_front());
        words_sent++;
      end
      if (in_push && in_full) full_stalls++;
      go = (words_to_send.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
      in_push <= go;
      if (go) begin
        in_word_a   <= words_to_send[0].word_a;
        in_word_b   <= words_to_send[0].word_b;
        in_font_row <= words_to_send[0].font_row;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each popped pixel against the oldest prediction and
  // drives pop with random stalls, or none at all while a hold is running.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_pop && !out_empty) begin
      pixels_checked++;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("pixel color %02h with nothing predicted", out_color));
      end else begin
        want = pixels_due.pop_front();
        if (out_color !== want.color)
          report_mismatch($sformatf("color %02h, predicted %02h", out_color, want.color));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, predicted %b", out_last, want.last));
      end
    end
    out_pop <= rst_n && (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long output hold, counted down in its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d pixels still predicted",
               cycle_cnt, pixels_due.size());
      $display("palette_pixel_serializer_unit_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // One register write; the shadow follows at the transfer edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_PIXEL_MODE:   mode_reg = val[3:0];
      CFG_PALETTE_LOW:  pal_lo = val;
      CFG_PALETTE_HIGH: pal_hi = val;
      default: ;  // unmapped index, dropped by the block
    endcase
  endtask

  task automatic set_idling(input idling_t how);
    case (how)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default:   begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
  endtask

  // Called away from the clock edge so the driver sees the batch cleanly.
  task automatic queue_word(input logic [31:0] wa, input logic [31:0] wb,
                            input logic [7:0] row);
    word_set_t w;
    w.word_a   = wa;
    w.word_b   = wb;
    w.font_row = row;
    words_to_send.push_back(w);
  endtask

  // Block is idle once every word has transferred and every pixel came out;
  // a settle wait then catches any stray pixel before the next config change.
  task automatic drain();
    while (words_to_send.size() != 0 || pixels_due.size() != 0 || in_push)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Directed item: switch mode if needed, send one word set, wait it out.
  task automatic word_in_mode(input logic [3:0] m, input logic [31:0] wa,
                              input logic [31:0] wb, input logic [7:0] row);
    if (m != mode_reg) write_reg(CFG_PIXEL_MODE, {60'd0, m});
    @(negedge clk);
    queue_word(wa, wb, row);
    drain();
  endtask

  // Mostly random words, with the all-zero and all-one extremes mixed in.
  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] any_palette();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_word_a      = '0;
    in_word_b      = '0;
    in_font_row    = '0;
    out_pop        = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_PIXEL_MODE;
    cfg_data       = '0;
    hold_arm       = 1'b0;
    mode_reg       = MODE_OFF;
    pal_lo         = PAL_LOW_RESET;
    pal_hi         = PAL_HIGH_RESET;
    err_cnt        = 0;
    words_sent     = 0;
    pixels_checked = 0;
    full_stalls    = 0;
    cfg_writes     = 0;
    cycle_cnt      = 0;
    set_idling(IDLE_NONE);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: every mode on the reset palette, field extremes ---
    word_in_mode(MODE_OFF,    $urandom(),   $urandom(),   8'($urandom()));
    word_in_mode(MODE_HI2,    32'h0000_0000, $urandom(),  8'($urandom()));
    word_in_mode(MODE_HI2,    32'hFFFF_FFFF, $urandom(),  8'($urandom()));
    word_in_mode(MODE_HI4,    32'hE4E4_E4E4, $urandom(),  8'($urandom()));
    word_in_mode(MODE_HI16,   32'h7654_3210, 32'hFEDC_BA98, 8'($urandom()));
    word_in_mode(MODE_HI16,   32'hFFFF_FFFF, 32'h0000_0000, 8'($urandom()));
    word_in_mode(MODE_LO2,    32'hA5A5_5A5A, $urandom(),  8'($urandom()));
    word_in_mode(MODE_LO4,    32'h1B1B_E4E4, $urandom(),  8'($urandom()));
    word_in_mode(MODE_LO16,   32'hFEDC_BA98, $urandom(),  8'($urandom()));
    word_in_mode(MODE_LO256,  32'h00FF_7F80, 32'hFFFF_0000, 8'($urandom()));
    // text: char code and upper half of word_a must not matter
    word_in_mode(MODE_LOTEXT, 32'h0000_F300, $urandom(),  8'hA5);
    word_in_mode(MODE_LOTEXT, 32'hFFFF_0FFF, $urandom(),  8'hFF);
    word_in_mode(MODE_HITEXT, 32'h0000_1E00, $urandom(),  8'h01);
    word_in_mode(MODE_HITEXT, 32'hFFFF_FFFF, $urandom(),  8'h00);
    // unknown codes, both ends of the range
    word_in_mode(MODE_FIRST_UNKNOWN, $urandom(), $urandom(), 8'($urandom()));
    word_in_mode(MODE_LAST_UNKNOWN,  $urandom(), $urandom(), 8'($urandom()));

    // palette extremes: entry 0 all ones shows up in mode off
    write_reg(CFG_PALETTE_LOW,  '1);
    write_reg(CFG_PALETTE_HIGH, '0);
    word_in_mode(MODE_OFF,  $urandom(), $urandom(), 8'($urandom()));
    word_in_mode(MODE_HI16, $urandom(), $urandom(), 8'($urandom()));
    write_reg(CFG_PALETTE_LOW,  '0);
    write_reg(CFG_PALETTE_HIGH, '1);
    word_in_mode(MODE_LO16, $urandom(), $urandom(), 8'($urandom()));
    // write to the unmapped index must leave the palette alone
    write_reg(CFG_UNUSED, {$urandom(), $urandom()});
    word_in_mode(MODE_HI4, $urandom(), $urandom(), 8'($urandom()));

    // --- pressure: stop popping while the sender keeps pushing lores2 words ---
    write_reg(CFG_PALETTE_LOW,  {$urandom(), $urandom()});
    write_reg(CFG_PALETTE_HIGH, {$urandom(), $urandom()});
    write_reg(CFG_PIXEL_MODE, {60'd0, MODE_LO2});
    set_idling(IDLE_NONE);
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    @(negedge clk);
    repeat (PRESS_WORDS) queue_word($urandom(), $urandom(), 8'($urandom()));
    drain();

    // --- random phases: new mode and maybe palette per phase, rotating idling ---
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_PIXEL_MODE,
                  {60'd0, 4'($urandom_range(MODE_FIRST_UNKNOWN, MODE_LAST_UNKNOWN))});
      else
        write_reg(CFG_PIXEL_MODE, {60'd0, 4'($urandom_range(MODE_OFF, MODE_HITEXT))});
      if ($urandom_range(0, 1) != 0) write_reg(CFG_PALETTE_LOW, any_palette());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_PALETTE_HIGH, any_palette());
      set_idling(idling_t'(ph % 4));
      @(negedge clk);
      repeat (PHASE_WORDS) queue_word(any_word(), any_word(), 8'(any_word()));
      drain();
    end

    $display("covered: %0d words, %0d pixels checked, %0d config writes",
             words_sent, pixels_checked, cfg_writes);
    $display("every defined mode, both ends of the unknown codes, palette extremes, %0d %s",
             full_stalls, "cycles with input held by full");
    if (err_cnt == 0) begin
      $display("palette_pixel_serializer_unit_tb OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("palette_pixel_serializer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ppsu_pkg.sv
src/ppsu_front.sv
src/ppsu_queue.sv
src/ppsu_back.sv
src/palette_pixel_serializer_unit.sv
sim/palette_pixel_serializer_unit_tb.sv
